[rtl/uart_rb_pkg.sv]
// Shared types, codes and helper functions for the UART ring buffer block.
`timescale 1ns / 1ps

package uart_rb_pkg;

	localparam int DEF_TX_DEPTH = 256;
	localparam int DEF_RX_DEPTH = 256;

	// Ring lengths are 9-bit values between 2 and 256.
	localparam int LEN_W     = 9;
	localparam int LEN_LIMIT = 256;
	localparam int LEN_MIN   = 2;

	localparam int DATA_W  = 8;
	localparam int REQ_W   = 3;
	localparam int STAT_W  = 2;
	localparam int CNT_W   = 8;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [REQ_W-1:0] REQ_PUT      = 3'd0;
	localparam logic [REQ_W-1:0] REQ_GET      = 3'd1;
	localparam logic [REQ_W-1:0] REQ_LINE_RX  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_TX_READY = 3'd3;
	localparam logic [REQ_W-1:0] REQ_PURGE_RX = 3'd4;
	localparam logic [REQ_W-1:0] REQ_PURGE_TX = 3'd5;

	localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	localparam logic REG_TX_LEN = 1'b0;
	localparam logic REG_RX_LEN = 1'b1;

	typedef struct packed {
		logic capture;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic             tx_we;
		logic             rx_we;
		logic [LEN_W-1:0] value;
	} cfg_wr_t;

	function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v,
	                                               input logic [LEN_W-1:0] limit);
		logic [LEN_W-1:0] l;
		if (v < LEN_W'(LEN_MIN)) begin
			l = LEN_W'(LEN_MIN);
		end else if (v > LEN_W'(LEN_LIMIT)) begin
			l = LEN_W'(LEN_LIMIT);
		end else begin
			l = v;
		end
		if (l > limit) begin
			l = limit;
		end
		return l;
	endfunction

	function automatic logic [LEN_W-1:0] next_ptr(input logic [LEN_W-1:0] p,
	                                              input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] inc;
		inc = p + LEN_W'(1);
		return (inc >= len) ? '0 : inc;
	endfunction

	function automatic logic [LEN_W-1:0] ring_count(input logic [LEN_W-1:0] wp,
	                                                input logic [LEN_W-1:0] rp,
	                                                input logic [LEN_W-1:0] len);
		return (wp >= rp) ? (wp - rp) : (wp + len - rp);
	endfunction

endpackage

[rtl/uart_tx_rx_ring_buffers.sv]
// Top level of the transmit and receive ring buffers with their register port.
//
//   Port group   Direction  Handshake           Word
//   request      in         in_valid/in_stall   req_type, data_in
//   result       out        out_valid/out_stall status, data_out, data_valid,
//                                               tx_free, rx_count, tx_irq_enable
//   registers    in/out     APB-style           tx_len at 0x0, rx_len at 0x4
//
// Each request is accepted in the idle state, while both stores read at their
// read pointers, then passes through an execute state that updates the ring and
// loads the result register. A stalled result holds the execute state until
// the result register frees up. Reset clears the pointers and the interrupt
// enable and sets both lengths to their full value at once; the byte stores
// need no clearing pass.
`timescale 1ns / 1ps

module uart_tx_rx_ring_buffers
	import uart_rb_pkg::*;
#(
	parameter int TX_DEPTH = DEF_TX_DEPTH,
	parameter int RX_DEPTH = DEF_RX_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [REQ_W-1:0]   req_type,
	input  logic [DATA_W-1:0]  data_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [STAT_W-1:0]  status,
	output logic [DATA_W-1:0]  data_out,
	output logic               data_valid,
	output logic [CNT_W-1:0]   tx_free,
	output logic [CNT_W-1:0]   rx_count,
	output logic               tx_irq_enable,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	ctrl_cmd_t        cmd;
	cfg_wr_t          cfg;
	logic             wr_en;
	logic [LEN_W-1:0] tx_len, rx_len;

	assign pready    = 1'b1;
	assign wr_en     = psel && penable && pwrite && pready;
	assign cfg.tx_we = wr_en && (paddr[2] == REG_TX_LEN);
	assign cfg.rx_we = wr_en && (paddr[2] == REG_RX_LEN);
	assign cfg.value = pwdata[LEN_W-1:0];
	assign prdata    = (paddr[2] == REG_RX_LEN) ? PDATA_W'(rx_len) : PDATA_W'(tx_len);

	uart_rb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd)
	);

	uart_rb_dp #(
		.TX_DEPTH(TX_DEPTH),
		.RX_DEPTH(RX_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg),
		.req_type     (req_type),
		.data_in      (data_in),
		.status       (status),
		.data_out     (data_out),
		.data_valid   (data_valid),
		.tx_free      (tx_free),
		.rx_count     (rx_count),
		.tx_irq_enable(tx_irq_enable),
		.tx_len       (tx_len),
		.rx_len       (rx_len)
	);

endmodule

[rtl/uart_rb_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module uart_rb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/uart_rb_ctrl.sv]
// Controller: sequences one request at a time and owns the result valid flag.
`timescale 1ns / 1ps

module uart_rb_ctrl
	import uart_rb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	output logic      out_valid,
	input  logic      out_stall,
	output ctrl_cmd_t cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic state_d;
	logic out_valid_q;
	logic out_free;

	// The result register can take a new word when empty or being emptied.
	assign out_free    = !out_valid_q || !out_stall;
	assign in_stall    = (state_q != S_IDLE);
	assign cmd.capture = in_valid && (state_q == S_IDLE);
	assign cmd.commit  = (state_q == S_EXEC) && out_free;
	assign out_valid   = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.capture) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (cmd.commit) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/uart_rb_dp.sv]
// Datapath: ring pointers, lengths, byte stores and the result register.
`timescale 1ns / 1ps

module uart_rb_dp
	import uart_rb_pkg::*;
#(
	parameter int TX_DEPTH = DEF_TX_DEPTH,
	parameter int RX_DEPTH = DEF_RX_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_cmd_t          cmd,
	input  cfg_wr_t            cfg,
	input  logic [REQ_W-1:0]   req_type,
	input  logic [DATA_W-1:0]  data_in,
	output logic [STAT_W-1:0]  status,
	output logic [DATA_W-1:0]  data_out,
	output logic               data_valid,
	output logic [CNT_W-1:0]   tx_free,
	output logic [CNT_W-1:0]   rx_count,
	output logic               tx_irq_enable,
	output logic [LEN_W-1:0]   tx_len,
	output logic [LEN_W-1:0]   rx_len
);

	// Only the first 256 slots of a ring can ever be used.
	localparam int TX_RD = (TX_DEPTH < LEN_LIMIT) ? TX_DEPTH : LEN_LIMIT;
	localparam int RX_RD = (RX_DEPTH < LEN_LIMIT) ? RX_DEPTH : LEN_LIMIT;
	localparam int TX_AW = $clog2(TX_RD);
	localparam int RX_AW = $clog2(RX_RD);
	localparam logic [LEN_W-1:0] TX_MAX = LEN_W'(TX_RD);
	localparam logic [LEN_W-1:0] RX_MAX = LEN_W'(RX_RD);

	logic [REQ_W-1:0]  req_q;
	logic [DATA_W-1:0] din_q;

	logic [TX_AW-1:0] tx_wp_q, tx_rp_q, tx_wp_d, tx_rp_d, tx_wp_nx, tx_rp_nx;
	logic [RX_AW-1:0] rx_wp_q, rx_rp_q, rx_wp_d, rx_rp_d, rx_wp_nx, rx_rp_nx;
	logic [LEN_W-1:0] tx_len_q, rx_len_q;
	logic             irq_q, irq_d;

	logic              tx_full, tx_empty, rx_full, rx_empty;
	logic              tx_we, rx_we;
	logic [DATA_W-1:0] tx_rdata, rx_rdata;

	logic [STAT_W-1:0] stat_d;
	logic [DATA_W-1:0] dout_d;
	logic              dvalid_d;
	logic [LEN_W-1:0]  tx_cnt_d, rx_cnt_d, tx_free_d;

	logic [STAT_W-1:0] status_q;
	logic [DATA_W-1:0] dout_q;
	logic              dvalid_q;
	logic [CNT_W-1:0]  tx_free_q, rx_cnt_q;
	logic              irq_out_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_type;
			din_q <= data_in;
		end
	end

	assign tx_wp_nx = TX_AW'(next_ptr(LEN_W'(tx_wp_q), tx_len_q));
	assign tx_rp_nx = TX_AW'(next_ptr(LEN_W'(tx_rp_q), tx_len_q));
	assign rx_wp_nx = RX_AW'(next_ptr(LEN_W'(rx_wp_q), rx_len_q));
	assign rx_rp_nx = RX_AW'(next_ptr(LEN_W'(rx_rp_q), rx_len_q));

	assign tx_full  = (tx_wp_nx == tx_rp_q);
	assign tx_empty = (tx_wp_q == tx_rp_q);
	assign rx_full  = (rx_wp_nx == rx_rp_q);
	assign rx_empty = (rx_wp_q == rx_rp_q);

	assign tx_we = cmd.commit && (req_q == REQ_PUT) && !tx_full;
	assign rx_we = cmd.commit && (req_q == REQ_LINE_RX) && !rx_full;

	// Both stores read continuously at their read pointers, so the oldest byte
	// is already registered by the cycle after a request is taken.
	uart_rb_ram #(
		.WIDTH(DATA_W),
		.DEPTH(TX_RD)
	) u_tx_ram (
		.clk  (clk),
		.we   (tx_we),
		.waddr(tx_wp_q),
		.wdata(din_q),
		.raddr(tx_rp_q),
		.rdata(tx_rdata)
	);

	uart_rb_ram #(
		.WIDTH(DATA_W),
		.DEPTH(RX_RD)
	) u_rx_ram (
		.clk  (clk),
		.we   (rx_we),
		.waddr(rx_wp_q),
		.wdata(din_q),
		.raddr(rx_rp_q),
		.rdata(rx_rdata)
	);

	always_comb begin
		tx_wp_d  = tx_wp_q;
		tx_rp_d  = tx_rp_q;
		rx_wp_d  = rx_wp_q;
		rx_rp_d  = rx_rp_q;
		irq_d    = irq_q;
		stat_d   = STAT_DONE;
		dout_d   = '0;
		dvalid_d = 1'b0;
		unique case (req_q)
			REQ_PUT: begin
				if (tx_full) begin
					stat_d = STAT_FULL;
				end else begin
					tx_wp_d = tx_wp_nx;
					irq_d   = 1'b1;
				end
			end
			REQ_GET: begin
				if (rx_empty) begin
					stat_d = STAT_EMPTY;
				end else begin
					dout_d   = rx_rdata;
					dvalid_d = 1'b1;
					rx_rp_d  = rx_rp_nx;
				end
			end
			REQ_LINE_RX: begin
				if (rx_full) begin
					stat_d = STAT_FULL;
				end else begin
					rx_wp_d = rx_wp_nx;
				end
			end
			REQ_TX_READY: begin
				if (tx_empty) begin
					stat_d = STAT_EMPTY;
					irq_d  = 1'b0;
				end else begin
					dout_d   = tx_rdata;
					dvalid_d = 1'b1;
					tx_rp_d  = tx_rp_nx;
				end
			end
			REQ_PURGE_RX: begin
				rx_wp_d = '0;
				rx_rp_d = '0;
			end
			REQ_PURGE_TX: begin
				tx_wp_d = '0;
				tx_rp_d = '0;
				irq_d   = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign tx_cnt_d  = ring_count(LEN_W'(tx_wp_d), LEN_W'(tx_rp_d), tx_len_q);
	assign rx_cnt_d  = ring_count(LEN_W'(rx_wp_d), LEN_W'(rx_rp_d), rx_len_q);
	assign tx_free_d = tx_len_q - LEN_W'(1) - tx_cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_wp_q  <= '0;
			tx_rp_q  <= '0;
			rx_wp_q  <= '0;
			rx_rp_q  <= '0;
			tx_len_q <= TX_MAX;
			rx_len_q <= RX_MAX;
			irq_q    <= 1'b0;
		end else begin
			if (cmd.commit) begin
				tx_wp_q <= tx_wp_d;
				tx_rp_q <= tx_rp_d;
				rx_wp_q <= rx_wp_d;
				rx_rp_q <= rx_rp_d;
				irq_q   <= irq_d;
			end
			// A length write empties that ring.
			if (cfg.tx_we) begin
				tx_len_q <= clamp_len(cfg.value, TX_MAX);
				tx_wp_q  <= '0;
				tx_rp_q  <= '0;
			end
			if (cfg.rx_we) begin
				rx_len_q <= clamp_len(cfg.value, RX_MAX);
				rx_wp_q  <= '0;
				rx_rp_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q  <= stat_d;
			dout_q    <= dout_d;
			dvalid_q  <= dvalid_d;
			tx_free_q <= tx_free_d[CNT_W-1:0];
			rx_cnt_q  <= rx_cnt_d[CNT_W-1:0];
			irq_out_q <= irq_d;
		end
	end

	assign status        = status_q;
	assign data_out      = dout_q;
	assign data_valid    = dvalid_q;
	assign tx_free       = tx_free_q;
	assign rx_count      = rx_cnt_q;
	assign tx_irq_enable = irq_out_q;
	assign tx_len        = tx_len_q;
	assign rx_len        = rx_len_q;

endmodule

[rtl/uart_rb_chk.sv]
// Port-level checks for the ring buffer block, bound to the top level.
`timescale 1ns / 1ps

module uart_rb_chk
	import uart_rb_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [STAT_W-1:0] status,
	input logic [DATA_W-1:0] data_out,
	input logic              data_valid
);

	// One request at a time: the cycle after a word is taken, input is stalled.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request accepted while another is in flight");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(status)
			&& $stable(data_out) && $stable(data_valid)))
		else $error("stalled result changed");

	a_data_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && data_valid) |-> (status == STAT_DONE))
		else $error("byte returned with a failure status");

	a_no_data_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !data_valid) |-> (data_out == '0))
		else $error("data_out not zero without a byte");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STAT_DONE || status == STAT_FULL
			|| status == STAT_EMPTY))
		else $error("undefined status code");

endmodule

bind uart_tx_rx_ring_buffers uart_rb_chk u_chk (.*);

[verif/uart_tx_rx_ring_buffers_tb.sv]
// Self-checking testbench for the transmit and receive ring buffers with their register port.
`timescale 1ns / 1ps

module uart_tx_rx_ring_buffers_tb;
	import uart_rb_pkg::*;

	localparam int CLK_HALF    = 10;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;

	// Request codes the block leaves unused.
	localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [REQ_W-1:0]  req;
		logic [DATA_W-1:0] data;
	} req_word_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [DATA_W-1:0] data_out;
		logic              data_valid;
		logic [CNT_W-1:0]  tx_free;
		logic [CNT_W-1:0]  rx_count;
		logic              tx_irq_enable;
	} ring_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [REQ_W-1:0]   req_type = '0;
	logic [DATA_W-1:0]  data_in = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [STAT_W-1:0]  status;
	logic [DATA_W-1:0]  data_out;
	logic               data_valid;
	logic [CNT_W-1:0]   tx_free;
	logic [CNT_W-1:0]   rx_count;
	logic               tx_irq_enable;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	uart_tx_rx_ring_buffers dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.data_in      (data_in),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.data_out     (data_out),
		.data_valid   (data_valid),
		.tx_free      (tx_free),
		.rx_count     (rx_count),
		.tx_irq_enable(tx_irq_enable),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #(CLK_HALF) clk = ~clk;

	// Shadow copy of both rings.
	logic [DATA_W-1:0] tx_bytes [DEF_TX_DEPTH];
	logic [DATA_W-1:0] rx_bytes [DEF_RX_DEPTH];
	logic [LEN_W-1:0]  tx_ring_len = LEN_W'(LEN_LIMIT);
	logic [LEN_W-1:0]  rx_ring_len = LEN_W'(LEN_LIMIT);
	logic [LEN_W-1:0]  tx_wr = '0, tx_rd = '0, rx_wr = '0, rx_rd = '0;
	logic              tx_irq_shadow = 1'b0;

	req_word_t    pending_words [$];
	ring_result_t awaited_results [$];
	req_word_t    next_word;
	ring_result_t got, want;

	int  in_gap = 0;
	int  stall_left = 0;
	int  hold_left = 0;
	bit  hold_req = 1'b0;
	bit  hold_taken = 1'b0;
	bit  quiet = 1'b0;
	int  errors = 0;
	int  checked = 0;
	int  full_hits = 0;
	int  empty_hits = 0;
	int  len_settings = 0;
	int  cycle_count = 0;

	function automatic logic [LEN_W-1:0] ring_advance(input logic [LEN_W-1:0] p,
	                                                  input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] p1;
		p1 = p + LEN_W'(1);
		return (p1 >= len) ? '0 : p1;
	endfunction

	function automatic logic [LEN_W-1:0] ring_fill(input logic [LEN_W-1:0] wp,
	                                               input logic [LEN_W-1:0] rp,
	                                               input logic [LEN_W-1:0] len);
		return (wp >= rp) ? (wp - rp) : (wp + len - rp);
	endfunction

	function automatic logic [LEN_W-1:0] len_from_write(input logic [PDATA_W-1:0] v);
		logic [LEN_W-1:0] raw;
		raw = v[LEN_W-1:0];
		if (raw < LEN_W'(LEN_MIN))
			return LEN_W'(LEN_MIN);
		if (raw > LEN_W'(LEN_LIMIT))
			return LEN_W'(LEN_LIMIT);
		return raw;
	endfunction

	function automatic ring_result_t predict_ring_result(input logic [REQ_W-1:0] req,
	                                                     input logic [DATA_W-1:0] b);
		ring_result_t r;
		logic [LEN_W-1:0] nxt;
		r = '0;
		r.status = STAT_DONE;
		case (req)
			REQ_PUT: begin
				nxt = ring_advance(tx_wr, tx_ring_len);
				if (nxt == tx_rd) begin
					r.status = STAT_FULL;
				end else begin
					tx_bytes[tx_wr[DATA_W-1:0]] = b;
					tx_wr = nxt;
					tx_irq_shadow = 1'b1;
				end
			end
			REQ_GET: begin
				if (rx_rd == rx_wr) begin
					r.status = STAT_EMPTY;
				end else begin
					r.data_out = rx_bytes[rx_rd[DATA_W-1:0]];
					r.data_valid = 1'b1;
					rx_rd = ring_advance(rx_rd, rx_ring_len);
				end
			end
			REQ_LINE_RX: begin
				nxt = ring_advance(rx_wr, rx_ring_len);
				if (nxt == rx_rd) begin
					r.status = STAT_FULL;
				end else begin
					rx_bytes[rx_wr[DATA_W-1:0]] = b;
					rx_wr = nxt;
				end
			end
			REQ_TX_READY: begin
				if (tx_wr == tx_rd) begin
					r.status = STAT_EMPTY;
					tx_irq_shadow = 1'b0;
				end else begin
					r.data_out = tx_bytes[tx_rd[DATA_W-1:0]];
					r.data_valid = 1'b1;
					tx_rd = ring_advance(tx_rd, tx_ring_len);
				end
			end
			REQ_PURGE_RX: begin
				rx_wr = '0;
				rx_rd = '0;
			end
			REQ_PURGE_TX: begin
				tx_wr = '0;
				tx_rd = '0;
				tx_irq_shadow = 1'b0;
			end
			default: ;
		endcase
		r.tx_free = CNT_W'(tx_ring_len - LEN_W'(1) - ring_fill(tx_wr, tx_rd, tx_ring_len));
		r.rx_count = CNT_W'(ring_fill(rx_wr, rx_rd, rx_ring_len));
		r.tx_irq_enable = tx_irq_shadow;
		return r;
	endfunction

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("ERROR: %s", msg);
	endtask

	// Request driver: a word stays on the bus until it is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				awaited_results.push_back(predict_ring_result(req_type, data_in));
			if (!in_valid || !in_stall) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					next_word = pending_words.pop_front();
					in_valid <= 1'b1;
					req_type <= next_word.req;
					data_in <= next_word.data;
					if (!quiet && $urandom_range(0, 99) < 12)
						in_gap = $urandom_range(1, 17);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result back-pressure, including one long hold-off on request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (!quiet && $urandom_range(0, 99) < 10)
					stall_left = $urandom_range(1, 17);
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got = {status, data_out, data_valid, tx_free, rx_count, tx_irq_enable};
			if (awaited_results.size() == 0) begin
				flag_error($sformatf("result with none awaited: status %0d data %02h/%0b tx_free %0d rx_count %0d irq %0b",
					got.status, got.data_out, got.data_valid, got.tx_free,
					got.rx_count, got.tx_irq_enable));
			end else begin
				want = awaited_results.pop_front();
				checked++;
				if (want.status == STAT_FULL)
					full_hits++;
				if (want.status == STAT_EMPTY)
					empty_hits++;
				if (got !== want)
					flag_error($sformatf({"result %0d: expected status %0d data %02h/%0b tx_free %0d ",
						"rx_count %0d irq %0b, got status %0d data %02h/%0b tx_free %0d ",
						"rx_count %0d irq %0b"}, checked,
						want.status, want.data_out, want.data_valid, want.tx_free,
						want.rx_count, want.tx_irq_enable,
						got.status, got.data_out, got.data_valid, got.tx_free,
						got.rx_count, got.tx_irq_enable));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding.",
				cycle_count, awaited_results.size());
			$display("status: fail");
			$finish;
		end
	end

	task automatic add_word(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] b);
		pending_words.push_back('{req: req, data: b});
	endtask

	task automatic wait_idle(input int tail);
		while (pending_words.size() != 0 || in_valid || awaited_results.size() != 0)
			@(negedge clk);
		repeat (tail) @(negedge clk);
	endtask

	// Register write with a setup and an access phase; a length write also empties that ring.
	task automatic write_ring_len(input logic sel, input logic [PDATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({sel, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (sel == REG_TX_LEN) begin
			tx_ring_len = len_from_write(value);
			tx_wr = '0;
			tx_rd = '0;
		end else begin
			rx_ring_len = len_from_write(value);
			rx_wr = '0;
			rx_rd = '0;
		end
		@(negedge clk);
	endtask

	task automatic queue_mix(input int n, input bit put_heavy);
		int r;
		logic [REQ_W-1:0] code;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (put_heavy)
				code = (r < 90) ? REQ_PUT : REQ_W'($urandom_range(REQ_GET, REQ_SPARE_HI));
			else if (r < 22)
				code = REQ_PUT;
			else if (r < 44)
				code = REQ_GET;
			else if (r < 66)
				code = REQ_LINE_RX;
			else if (r < 88)
				code = REQ_TX_READY;
			else if (r < 92)
				code = REQ_PURGE_RX;
			else if (r < 96)
				code = REQ_PURGE_TX;
			else
				code = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
			add_word(code, DATA_W'($urandom));
		end
	endtask

	task automatic start_phase(input logic [PDATA_W-1:0] tx_val,
	                           input logic [PDATA_W-1:0] rx_val);
		wait_idle(4);
		write_ring_len(REG_TX_LEN, tx_val);
		write_ring_len(REG_RX_LEN, rx_val);
		len_settings++;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty rings at full length, data extremes, purges and unused codes.
		add_word(REQ_GET, 8'h00);
		add_word(REQ_TX_READY, 8'h00);
		add_word(REQ_PUT, 8'h00);
		add_word(REQ_PUT, 8'hFF);
		add_word(REQ_TX_READY, 8'h00);
		add_word(REQ_TX_READY, 8'h00);
		add_word(REQ_TX_READY, 8'h00);
		add_word(REQ_LINE_RX, 8'hFF);
		add_word(REQ_LINE_RX, 8'h00);
		add_word(REQ_GET, 8'h00);
		add_word(REQ_GET, 8'h00);
		add_word(REQ_GET, 8'h00);
		add_word(REQ_PUT, 8'hA5);
		add_word(REQ_PURGE_TX, 8'h00);
		add_word(REQ_TX_READY, 8'h00);
		add_word(REQ_LINE_RX, 8'h5A);
		add_word(REQ_PURGE_RX, 8'h00);
		add_word(REQ_GET, 8'h00);
		add_word(REQ_SPARE_LO, 8'hFF);
		add_word(REQ_SPARE_HI, 8'h00);

		// Writes below the minimum clamp to two slots, so one byte fills each ring.
		start_phase(32'd1, 32'd0);
		add_word(REQ_PUT, 8'h11);
		add_word(REQ_PUT, 8'h22);
		add_word(REQ_LINE_RX, 8'h33);
		add_word(REQ_LINE_RX, 8'h44);
		add_word(REQ_TX_READY, 8'h00);
		add_word(REQ_GET, 8'h00);
		queue_mix(40, 1'b0);

		// Fill the full-length transmit ring past full while results are held off.
		start_phase(32'd257, 32'd3);
		queue_mix(300, 1'b1);
		hold_req = 1'b1;

		start_phase(32'h0000_0203, 32'd256);
		queue_mix(40, 1'b0);

		start_phase($urandom_range(LEN_MIN, 12), $urandom_range(LEN_MIN, 12));
		queue_mix(40, 1'b0);

		start_phase($urandom, $urandom);
		queue_mix(40, 1'b0);

		start_phase(32'd255, 32'd5);
		quiet = 1'b1;
		queue_mix(40, 1'b0);

		wait_idle(10);
		if (awaited_results.size() != 0)
			flag_error($sformatf("%0d results never arrived", awaited_results.size()));
		$display("Checked %0d request words over %0d ring-length settings plus reset lengths.",
			checked, len_settings);
		$display("Saw %0d full and %0d empty outcomes; %0d errors.", full_hits, empty_hits, errors);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[filelist.f]
rtl/uart_rb_pkg.sv
rtl/uart_rb_ram.sv
rtl/uart_rb_ctrl.sv
rtl/uart_rb_dp.sv
rtl/uart_tx_rx_ring_buffers.sv
rtl/uart_rb_chk.sv
verif/uart_tx_rx_ring_buffers_tb.sv
